>>> rtl/tmv_pkg.sv
`timescale 1ns / 1ps

package tmv_pkg;

  localparam int IDX_W = 8;
  localparam int INDEX_SPAN = 1 << IDX_W;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int SUM_W = 48;
  localparam int MATRIX_SIZE_DEFAULT = 256;
  localparam int STORE_DEPTH_DEFAULT = 256;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_MAC  = 2'd1,
    MODE_READ = 2'd2
  } tmv_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_WB
  } tmv_state_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [ELEM_W-1:0] element_value;
    logic                    tile_row_end;
  } tmv_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic                    sum_valid;
  } tmv_out_t;

  // Control for one memory: a write port and a read port.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } tmv_mem_ctl_t;

endpackage

>>> rtl/tmv_vec_mem.sv
`timescale 1ns / 1ps

module tmv_vec_mem #(
  parameter int DEPTH = tmv_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  tmv_pkg::tmv_mem_ctl_t                ctl,
  input  logic signed [tmv_pkg::ELEM_W-1:0]    wr_data,
  output logic signed [tmv_pkg::ELEM_W-1:0]    rd_data
);
  import tmv_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr[ADDR_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

>>> rtl/tmv_res_mem.sv
`timescale 1ns / 1ps

module tmv_res_mem #(
  parameter int DEPTH = tmv_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tmv_pkg::tmv_mem_ctl_t      ctl,
  input  logic [tmv_pkg::SUM_W-1:0]  wr_data,
  output logic [tmv_pkg::SUM_W-1:0]  rd_data
);
  import tmv_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [SUM_W-1:0] rd_word;
  logic             rd_written;

  // An entry that has not been written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ctl.wr_en) begin
      written[ctl.wr_addr[ADDR_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr[ADDR_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_word    <= mem[ctl.rd_addr[ADDR_W-1:0]];
      rd_written <= written[ctl.rd_addr[ADDR_W-1:0]];
    end
  end

  assign rd_data = rd_written ? rd_word : '0;

endmodule

>>> rtl/tiled_matrix_vector_mac.sv
`timescale 1ns / 1ps

// Tiled matrix-vector multiply-accumulate. Each transfer on the item channel
// either loads a vector element, multiplies a matrix element by the stored
// vector element of its column and adds it into a running partial sum, or
// reads back one row result; every item produces exactly one transfer on
// the result channel (row_sum and sum_valid are zero except for an in-range
// read). A multiply item marked tile_row_end adds the partial sum and its own
// product into its row's result, if in range, and clears it. Items are
// processed one at a time through the multiply and accumulate steps (the
// latter registers the result and waits out result channel stalls) and, for
// a flush into an in-range row, a write-back step, before the next item is
// taken. The steps come from the registered reads of the vector and result
// memories, the registered multiplier and the result memory write-back. The
// result memory comes out of reset as all zeros immediately, with no clearing
// pass; the vector memory holds nothing meaningful until loaded.
module tiled_matrix_vector_mac #(
  parameter int MATRIX_SIZE = tmv_pkg::MATRIX_SIZE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tmv_pkg::tmv_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output tmv_pkg::tmv_out_t result
);
  import tmv_pkg::*;

  localparam int STORE_DEPTH = (MATRIX_SIZE < INDEX_SPAN) ? MATRIX_SIZE : INDEX_SPAN;

  tmv_state_t state, state_next;

  tmv_in_t                  cur;
  logic                     col_ok;
  logic                     row_ok;
  logic signed [PROD_W-1:0] product;
  logic [SUM_W-1:0]         partial_sum;
  logic [SUM_W-1:0]         flush_sum;
  logic [SUM_W-1:0]         acc_sum;

  tmv_mem_ctl_t             vec_ctl;
  tmv_mem_ctl_t             res_ctl;
  logic signed [ELEM_W-1:0] vec_rd;
  logic [SUM_W-1:0]         res_rd;

  logic item_fire;
  logic acc_go;
  logic is_flush;
  logic in_col_ok;
  logic in_row_ok;

  assign item_ready = (state == ST_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign in_col_ok  = (32'(item.col_index) < MATRIX_SIZE);
  assign in_row_ok  = (32'(item.row_index) < MATRIX_SIZE);
  // The result register must be free before an item can finish.
  assign acc_go     = (state == ST_ACC) && (!result_valid || result_ready);
  assign is_flush   = (cur.mode == MODE_MAC) && cur.tile_row_end;
  assign acc_sum    = partial_sum + SUM_W'(product);

  always_comb begin
    vec_ctl.wr_en   = item_fire && (item.mode == MODE_LOAD) && in_col_ok;
    vec_ctl.wr_addr = item.col_index;
    vec_ctl.rd_en   = item_fire && in_col_ok;
    vec_ctl.rd_addr = item.col_index;
    res_ctl.wr_en   = (state == ST_WB);
    res_ctl.wr_addr = cur.row_index;
    res_ctl.rd_en   = item_fire && in_row_ok;
    res_ctl.rd_addr = item.row_index;
  end

  tmv_vec_mem #(
    .DEPTH(STORE_DEPTH)
  ) u_vec_mem (
    .clk     (clk),
    .ctl     (vec_ctl),
    .wr_data (item.element_value),
    .rd_data (vec_rd)
  );

  tmv_res_mem #(
    .DEPTH(STORE_DEPTH)
  ) u_res_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (res_ctl),
    .wr_data (res_rd + flush_sum),
    .rd_data (res_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_fire) state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (acc_go) state_next = (is_flush && row_ok) ? ST_WB : ST_IDLE;
      end
      ST_WB: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      cur    <= item;
      col_ok <= in_col_ok;
      row_ok <= in_row_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      if ((cur.mode == MODE_MAC) && col_ok) begin
        product <= $signed(cur.element_value) * vec_rd;
      end else begin
        product <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_sum <= '0;
    end else if (acc_go && (cur.mode == MODE_MAC)) begin
      partial_sum <= cur.tile_row_end ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go) begin
      flush_sum <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (acc_go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go) begin
      if ((cur.mode == MODE_READ) && row_ok) begin
        result.row_sum   <= res_rd;
        result.sum_valid <= 1'b1;
      end else begin
        result.row_sum   <= '0;
        result.sum_valid <= 1'b0;
      end
    end
  end

  a_acc_waits_for_output: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_ACC && result_valid && !result_ready) |=> (state == ST_ACC)
  ) else $error("item finished while the result register was still occupied");

  a_flush_clears_partial: assert property (
    @(posedge clk) disable iff (rst)
    (acc_go && is_flush) |=> (partial_sum == '0)
  ) else $error("partial sum not cleared after a row flush");

  a_writeback_only_on_flush: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_WB) |-> (is_flush && row_ok && $past(acc_go))
  ) else $error("result write-back without an in-range row flush");

  a_accept_starts_item: assert property (
    @(posedge clk) disable iff (rst)
    item_fire |=> (state == ST_MUL)
  ) else $error("accepted item did not enter the multiply step");

endmodule
